// File: hw/rtl/nnact_pkg.sv
// Shared types, constants and fixed-point helpers for the activation unit.
// Holds the tanh coefficient table; no dependencies.
package nnact_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SEGMENTS   = 32;
    localparam int SEG_SHIFT  = 11;
    localparam int SCALE_DEC  = 10000;
    localparam longint COEF_DEN = 1000000000;

    localparam int DATA_W     = 32;
    localparam int SEG_W      = $clog2(SEGMENTS);
    localparam int ABS_W      = FRAC_BITS + 3;
    localparam int SCALE_W    = $clog2(SCALE_DEC + 1);
    localparam int SEGP_W     = ABS_W + SCALE_W;
    localparam int SEGR_W     = SEGP_W - FRAC_BITS - SEG_SHIFT;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int BACK_STAGES = 7;
    localparam int PIPE_CAP   = 1 + FIFO_DEPTH + BACK_STAGES;
    localparam int PEND_W     = $clog2(PIPE_CAP + 1);

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACT_KIND = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_PASS_DIR = CFG_INDEX_W'(1);

    localparam int COEF_C3 = 0;
    localparam int COEF_C2 = 1;
    localparam int COEF_C1 = 2;
    localparam int COEF_C0 = 3;

    localparam logic signed [DATA_W-1:0] ONE_Q    = DATA_W'(longint'(1) << FRAC_BITS);
    localparam logic signed [DATA_W-1:0] SIX_Q    = DATA_W'(longint'(6) << FRAC_BITS);
    localparam logic signed [DATA_W-1:0] TANH_LIM =
        DATA_W'((longint'(65536) << FRAC_BITS) / SCALE_DEC);

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    localparam longint TANH_RAW [SEGMENTS][4] = '{
        '{-323768137, 0, 999829378, 12}, '{-224577786, -60942552, 1012310413, -852027},
        '{-85294811, -232093472, 1082413830, -10423480},
        '{30060432, -444716255, 1213049268, -37177618},
        '{93805209, -601375420, 1341384456, -72221680},
        '{112109067, -657604872, 1398963414, -91875298},
        '{103550306, -626053856, 1360193527, -75995152},
        '{84237250, -542992262, 1241116425, -19092174},
        '{63665066, -441875863, 1075447316, 71385249},
        '{45976471, -344065011, 895162355, 182152329},
        '{32252527, -259745097, 722475170, 300040114},
        '{22203363, -191828827, 569473397, 414934245},
        '{15098239, -139444167, 440732858, 520398495},
        '{10183947, -100192739, 336229856, 613141426},
        '{6832574, -71365567, 253576587, 692135910},
        '{4567905, -50494378, 189460295, 757790993},
        '{3046723, -35540547, 140459581, 811312839},
        '{2028966, -24910282, 103449253, 854264559},
        '{1349801, -17399257, 75760608, 888288365},
        '{897363, -12117675, 55208919, 914945277},
        '{596306, -8418297, 40056265, 935633700},
        '{396132, -5835573, 28948485, 951557814},
        '{263102, -4037429, 20846768, 963725513},
        '{174724, -2788538, 14963994, 972962252},
        '{116020, -1922917, 10709291, 979933157},
        '{77044, -1324238, 7644057, 985164489},
        '{51128, -910244, 5439617, 989077223},
        '{34046, -626889, 3872778, 991965222},
        '{22230, -423612, 2707107, 994193362},
        '{16157, -315402, 2064429, 995465695},
        '{5511, -119165, 858748, 997934929},
        '{23128, -454708, 2989045, 993426652}
    };

    typedef enum logic [1:0] {
        ACT_TANH,
        ACT_SIGMOID,
        ACT_RELU,
        ACT_RELU6
    } act_kind_t;

    typedef enum logic [2:0] {
        OP_TANH,
        OP_SIGM,
        OP_DTANH,
        OP_DSIGM,
        OP_PASS
    } op_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] grad_in;
        logic                     last_in;
    } in_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     last_out;
    } out_beat_t;

    typedef struct packed {
        op_t                      op;
        logic                     fixed;
        logic                     neg;
        logic [SEG_W-1:0]         seg;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] g;
        logic signed [DATA_W-1:0] y;
        logic                     last;
    } item_t;

    function automatic logic signed [63:0] sext64(input logic signed [DATA_W-1:0] v);
        return {{(64 - DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        if (v > SAT_MAX) begin
            return SAT_MAX[DATA_W-1:0];
        end
        if (v < SAT_MIN) begin
            return SAT_MIN[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] qscale(input logic signed [63:0] prod);
        return sat32(prod >>> FRAC_BITS);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] x,
                                                         input logic signed [DATA_W-1:0] y);
        return sat32(sext64(x) + sext64(y));
    endfunction

    function automatic logic signed [DATA_W-1:0] coef_q(input int seg, input int k);
        longint v;
        v = (TANH_RAW[seg][k] * (longint'(1) << FRAC_BITS)) / COEF_DEN;
        return v[DATA_W-1:0];
    endfunction

endpackage

// File: hw/rtl/nn_activation_unit.sv
// Top level of the activation unit: front end, queue and back end.
// Depends on nnact_pkg, nnact_front, nnact_fifo and nnact_back.
//
// Usage:
//   Write act_kind (index 0: tanh, sigmoid, relu, relu6) and pass_dir (index 1:
//   forward or backward) through the cfg_* port while no beats are in flight.
//   Input beats carry a Q16.16 value, an upstream gradient (backward only) and
//   a last flag; each input beat yields exactly one output beat, in order.
//   Path: an accepted beat passes through the classification register, the
//   queue, six multiply/accumulate stages and the output register to m_valid.
//   Throughput: one beat per cycle while m_ready stays high, set by the
//   three-step Horner pipeline with one 32x32 multiplier per step.
//   Stall: a low m_ready holds the output beat and the back end; the queue
//   keeps taking beats until it fills, then s_ready drops. Up to 12 beats are
//   in flight.
//   Reset (aresetn low, synchronous): empties the pipeline and queue and sets
//   the configuration to forward tanh.
module nn_activation_unit
    import nnact_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_beat_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_beat_t              m_data
);

    logic  fr_valid;
    logic  fr_ready;
    item_t fr_item;
    logic  bk_valid;
    logic  bk_pop;
    item_t bk_item;

    nnact_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .fr_valid (fr_valid),
        .fr_ready (fr_ready),
        .fr_item  (fr_item)
    );

    nnact_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(fr_valid),
        .wr_ready(fr_ready),
        .wr_item (fr_item),
        .rd_valid(bk_valid),
        .rd_pop  (bk_pop),
        .rd_item (bk_item)
    );

    nnact_back u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .f_valid(bk_valid),
        .f_item (bk_item),
        .f_pop  (bk_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

endmodule

// File: hw/rtl/nnact_front.sv
// Front end: configuration registers, input beat acceptance and classification.
// Depends on nnact_pkg; feeds the queue in front of nnact_back.
module nnact_front
    import nnact_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_beat_t               s_data,
    output logic                   fr_valid,
    input  logic                   fr_ready,
    output item_t                  fr_item
);

    act_kind_t act_kind_reg;
    logic      pass_dir_reg;
    logic      front_valid_reg;
    logic      front_valid_next;
    item_t     front_item_reg;
    item_t     front_item_next;

    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] g;
    logic signed [DATA_W-1:0] t;
    logic signed [DATA_W-1:0] t_neg;
    logic [ABS_W-1:0]         a_abs;
    logic [SEGP_W-1:0]        seg_prod;
    logic [SEGR_W-1:0]        seg_raw;
    logic                     accept;

    assign s_ready  = !front_valid_reg || fr_ready;
    assign accept   = s_valid && s_ready;
    assign fr_valid = front_valid_reg;
    assign fr_item  = front_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_kind_reg <= ACT_TANH;
            pass_dir_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ACT_KIND: act_kind_reg <= act_kind_t'(cfg_data[1:0]);
                CFG_PASS_DIR: pass_dir_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        x       = s_data.value;
        g       = s_data.grad_in;
        t       = (act_kind_reg == ACT_SIGMOID) ? (x >>> 1) : x;
        t_neg   = -t;
        a_abs   = t[DATA_W-1] ? t_neg[ABS_W-1:0] : t[ABS_W-1:0];
        seg_prod = SEGP_W'(a_abs) * SEGP_W'(SCALE_DEC);
        seg_raw = seg_prod[SEGP_W-1:FRAC_BITS+SEG_SHIFT];

        front_item_next       = '0;
        front_item_next.last  = s_data.last_in;
        front_item_next.g     = g;
        front_item_next.a     = x;
        front_item_next.op    = OP_PASS;

        if (!pass_dir_reg) begin
            unique case (act_kind_reg) inside
                ACT_TANH, ACT_SIGMOID: begin
                    front_item_next.op  = (act_kind_reg == ACT_TANH) ? OP_TANH : OP_SIGM;
                    front_item_next.a   = DATA_W'(a_abs);
                    front_item_next.neg = t[DATA_W-1];
                    if (seg_raw > SEGR_W'(SEGMENTS - 1)) begin
                        front_item_next.seg = SEG_W'(SEGMENTS - 1);
                    end else begin
                        front_item_next.seg = seg_raw[SEG_W-1:0];
                    end
                    if (t == '0) begin
                        front_item_next.fixed = 1'b1;
                        front_item_next.neg   = 1'b0;
                        front_item_next.y     = '0;
                    end else if (t > TANH_LIM) begin
                        front_item_next.fixed = 1'b1;
                        front_item_next.neg   = 1'b0;
                        front_item_next.y     = ONE_Q;
                    end else if (t < -TANH_LIM) begin
                        front_item_next.fixed = 1'b1;
                        front_item_next.neg   = 1'b0;
                        front_item_next.y     = -ONE_Q;
                    end
                end
                ACT_RELU: begin
                    front_item_next.y = (x > 0) ? x : '0;
                end
                ACT_RELU6: begin
                    if (x < 0) begin
                        front_item_next.y = '0;
                    end else if (x > SIX_Q) begin
                        front_item_next.y = SIX_Q;
                    end else begin
                        front_item_next.y = x;
                    end
                end
            endcase
        end else begin
            unique case (act_kind_reg)
                ACT_TANH: begin
                    front_item_next.op = OP_DTANH;
                end
                ACT_SIGMOID: begin
                    front_item_next.op = OP_DSIGM;
                    front_item_next.y  = sat32(sext64(ONE_Q) - sext64(x));
                end
                ACT_RELU: begin
                    front_item_next.y = (x > 0) ? g : '0;
                end
                ACT_RELU6: begin
                    front_item_next.y = (x > 0 && x < SIX_Q) ? g : '0;
                end
            endcase
        end
    end

    always_comb begin
        front_valid_next = front_valid_reg;
        if (accept) begin
            front_valid_next = 1'b1;
        end else if (fr_ready) begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            front_item_reg <= front_item_next;
        end
    end

endmodule

// File: hw/rtl/nnact_fifo.sv
// Short queue of classified items between the front and back ends.
// Depends on nnact_pkg for the item type and depth.
module nnact_fifo
    import nnact_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_pop,
    output item_t rd_item
);

    item_t                 mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic [FIFO_CNT_W-1:0] cnt_next;
    logic                  push;
    logic                  pop;

    assign wr_ready = cnt_reg != FIFO_CNT_W'(FIFO_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;
    assign rd_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// File: hw/rtl/nnact_back.sv
// Back end: three multiply/accumulate steps, sign and sigmoid fix-up, output register.
// Depends on nnact_pkg for the item type, coefficients and saturation helpers.
module nnact_back
    import nnact_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      f_valid,
    input  item_t     f_item,
    output logic      f_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic signed [DATA_W-1:0] coef_rom [SEGMENTS][4];

    for (genvar i = 0; i < SEGMENTS; i++) begin : g_seg
        for (genvar k = 0; k < 4; k++) begin : g_term
            assign coef_rom[i][k] = coef_q(i, k);
        end
    end

    logic en;

    logic m1_valid_reg, a1_valid_reg, m2_valid_reg, a2_valid_reg;
    logic m3_valid_reg, a3_valid_reg, out_valid_reg;
    item_t m1_item_reg, a1_item_reg, m2_item_reg, a2_item_reg, m3_item_reg, a3_item_reg;
    item_t a1_item_next, a2_item_next, a3_item_next;
    logic signed [63:0] m1_prod_reg, m2_prod_reg, m3_prod_reg;
    logic signed [63:0] m1_prod_next, m2_prod_next, m3_prod_next;
    out_beat_t out_data_reg;
    out_beat_t out_data_next;

    logic signed [DATA_W-1:0] m1_opa, m1_opb, m2_opa, m2_opb, m3_opa, m3_opb;
    logic signed [DATA_W-1:0] q1, q2, q3;
    logic signed [DATA_W-1:0] tanh_val;
    logic signed [63:0]       sig_sum;

    assign en      = !out_valid_reg || m_ready;
    assign f_pop   = en && f_valid;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        m1_opa = f_item.a;
        unique case (f_item.op) inside
            OP_TANH, OP_SIGM: m1_opb = coef_rom[f_item.seg][COEF_C3];
            OP_DTANH:         m1_opb = f_item.a;
            default:          m1_opb = f_item.y;
        endcase
        m1_prod_next = m1_opa * m1_opb;

        q1           = qscale(m1_prod_reg);
        a1_item_next = m1_item_reg;
        unique case (m1_item_reg.op) inside
            OP_TANH, OP_SIGM: begin
                if (!m1_item_reg.fixed) begin
                    a1_item_next.y = sat_add(coef_rom[m1_item_reg.seg][COEF_C2], q1);
                end
            end
            OP_DTANH: a1_item_next.y = sat32(sext64(ONE_Q) - sext64(q1));
            OP_DSIGM: a1_item_next.y = q1;
            default: ;
        endcase

        m2_opa = a1_item_reg.y;
        unique case (a1_item_reg.op) inside
            OP_TANH, OP_SIGM: m2_opb = a1_item_reg.a;
            default:          m2_opb = a1_item_reg.g;
        endcase
        m2_prod_next = m2_opa * m2_opb;

        q2           = qscale(m2_prod_reg);
        a2_item_next = m2_item_reg;
        unique case (m2_item_reg.op) inside
            OP_TANH, OP_SIGM: begin
                if (!m2_item_reg.fixed) begin
                    a2_item_next.y = sat_add(coef_rom[m2_item_reg.seg][COEF_C1], q2);
                end
            end
            OP_DTANH, OP_DSIGM: a2_item_next.y = q2;
            default: ;
        endcase

        m3_opa       = a2_item_reg.y;
        m3_opb       = a2_item_reg.a;
        m3_prod_next = m3_opa * m3_opb;

        q3           = qscale(m3_prod_reg);
        a3_item_next = m3_item_reg;
        unique case (m3_item_reg.op) inside
            OP_TANH, OP_SIGM: begin
                if (!m3_item_reg.fixed) begin
                    a3_item_next.y = sat_add(coef_rom[m3_item_reg.seg][COEF_C0], q3);
                end
            end
            default: ;
        endcase

        tanh_val = a3_item_reg.neg ? sat32(64'sd0 - sext64(a3_item_reg.y)) : a3_item_reg.y;
        sig_sum  = (sext64(tanh_val) + sext64(ONE_Q)) >>> 1;
        out_data_next.last_out = a3_item_reg.last;
        unique case (a3_item_reg.op) inside
            OP_TANH: out_data_next.result = tanh_val;
            OP_SIGM: out_data_next.result = sig_sum[DATA_W-1:0];
            default: out_data_next.result = a3_item_reg.y;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg  <= 1'b0;
            a1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            a2_valid_reg  <= 1'b0;
            m3_valid_reg  <= 1'b0;
            a3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            m1_valid_reg  <= f_valid;
            a1_valid_reg  <= m1_valid_reg;
            m2_valid_reg  <= a1_valid_reg;
            a2_valid_reg  <= m2_valid_reg;
            m3_valid_reg  <= a2_valid_reg;
            a3_valid_reg  <= m3_valid_reg;
            out_valid_reg <= a3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_item_reg  <= f_item;
            m1_prod_reg  <= m1_prod_next;
            a1_item_reg  <= a1_item_next;
            m2_item_reg  <= a1_item_reg;
            m2_prod_reg  <= m2_prod_next;
            a2_item_reg  <= a2_item_next;
            m3_item_reg  <= a2_item_reg;
            m3_prod_reg  <= m3_prod_next;
            a3_item_reg  <= a3_item_next;
            out_data_reg <= out_data_next;
        end
    end

endmodule

// File: hw/rtl/nnact_checker.sv
// Port-level checks for nn_activation_unit, bound to the top level.
// Depends on nnact_pkg and the top-level port list.
module nnact_checker
    import nnact_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input in_beat_t               s_data,
    input logic                   m_valid,
    input logic                   m_ready,
    input out_beat_t              m_data
);

    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;

    always_comb begin
        pending_next = pending_reg;
        if (s_valid && s_ready && !(m_valid && m_ready)) begin
            pending_next = pending_reg + 1'b1;
        end else if (!(s_valid && s_ready) && m_valid && m_ready) begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input beat changed while waiting");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not empty after reset");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != '0)
        else $error("output beat without a pending input beat");

    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= PEND_W'(PIPE_CAP))
        else $error("more beats in flight than the pipeline holds");

endmodule

bind nn_activation_unit nnact_checker u_nnact_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_data   (s_data),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_data   (m_data)
);
